// File: rtl/nalsplit_pkg.sv
// Shared types and constants for the Annex-B NAL splitter.
package nalsplit_pkg;

  localparam int unsigned SLOTS       = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [63:0] MASK_RESET = 64'h0000_0187_0000_0000;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_SC   = 8'h01;
  localparam logic [7:0] BYTE_EPB  = 8'h03;

  localparam logic [2:0] POS_REJECT = 3'd4;

  // One transfer group: the results caused by one input byte
  typedef struct packed {
    logic [SLOTS-1:0][7:0] bytes;
    logic [SLOTS-1:0]      last;
    logic [1:0]            cnt_m1;
    logic                  first;
    logic [5:0]            utype;
  } grp_t;

endpackage

// File: rtl/nalsplit_front.sv
// Front end: start-code tracking, emulation-prevention removal and result grouping.
module nalsplit_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [63:0]         cfg_wr_data,
  input  logic                in_fire,
  input  logic [7:0]          in_byte,
  input  logic                in_end,
  output logic                push,
  output nalsplit_pkg::grp_t  push_grp
);

  logic [63:0] mask_r;
  logic        acc_r, acc_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        inside_r, inside_nxt;
  logic [5:0]  type_r, type_nxt;
  logic        pass_r, pass_nxt;
  logic [1:0]  zr_r, zr_nxt;
  logic        p_r, p_nxt;
  logic [7:0]  pbyte_r, pbyte_nxt;
  logic        head_r, head_nxt;

  logic        type_eff_pass;
  logic [5:0]  type_eff;
  logic        pass_eff;
  logic        head_eff;
  logic        pa;
  logic [1:0]  za;
  logic        mlast;
  logic        p_m;
  logic [7:0]  pb_m;
  logic [1:0]  zr_m;
  logic        inside_m;
  logic [2:0]  la;
  logic [2:0]  lb;
  logic [2:0]  total;
  logic [2:0]  j;

  assign type_eff      = inside_r ? type_r : in_byte[6:1];
  assign type_eff_pass = mask_r[in_byte[6:1]];
  assign pass_eff      = inside_r ? pass_r : type_eff_pass;
  assign head_eff      = inside_r ? head_r : 1'b1;

  always_comb begin
    pa       = 1'b0;
    za       = 2'd0;
    mlast    = 1'b0;
    p_m      = p_r;
    pb_m     = pbyte_r;
    zr_m     = zr_r;
    inside_m = inside_r;
    acc_nxt  = acc_r;
    pos_nxt  = pos_r;
    if (acc_r) begin
      inside_m = 1'b1;
      if (in_byte == nalsplit_pkg::BYTE_ZERO) begin
        if (zr_r != 2'd3) begin
          zr_m = zr_r + 2'd1;
        end else if (p_r) begin
          pa   = 1'b1;
          p_m  = ~in_end;
          pb_m = nalsplit_pkg::BYTE_ZERO;
        end else begin
          p_m  = 1'b1;
          pb_m = nalsplit_pkg::BYTE_ZERO;
        end
      end else if (in_byte == nalsplit_pkg::BYTE_SC && zr_r >= 2'd2) begin
        pa       = p_r;
        mlast    = p_r;
        p_m      = 1'b0;
        zr_m     = 2'd0;
        inside_m = 1'b0;
      end else if (in_byte == nalsplit_pkg::BYTE_EPB && zr_r >= 2'd2) begin
        pa   = p_r;
        za   = zr_r - 2'd1;
        p_m  = 1'b1;
        pb_m = nalsplit_pkg::BYTE_ZERO;
        zr_m = 2'd0;
      end else begin
        pa   = p_r;
        za   = (in_end && p_r && zr_r == 2'd3) ? 2'd2 : zr_r;
        p_m  = 1'b1;
        pb_m = in_byte;
        zr_m = 2'd0;
      end
    end else if (pos_r < nalsplit_pkg::POS_REJECT) begin
      if (pos_r < 3'd2) begin
        pos_nxt = (in_byte == nalsplit_pkg::BYTE_ZERO) ? pos_r + 3'd1
                                                       : nalsplit_pkg::POS_REJECT;
      end else if (in_byte == nalsplit_pkg::BYTE_SC) begin
        acc_nxt  = 1'b1;
        inside_m = 1'b0;
        zr_m     = 2'd0;
        p_m      = 1'b0;
      end else if (pos_r == 3'd2 && in_byte == nalsplit_pkg::BYTE_ZERO) begin
        pos_nxt = 3'd3;
      end else begin
        pos_nxt = nalsplit_pkg::POS_REJECT;
      end
    end

    la    = {2'b0, pa} + {1'b0, za};
    lb    = in_end ? ({2'b0, p_m} + {1'b0, zr_m}) : 3'd0;
    total = la + lb;

    push_grp        = '0;
    push_grp.first  = head_eff;
    push_grp.utype  = type_eff;
    push_grp.cnt_m1 = 2'(total - 3'd1);
    for (int i = 0; i < nalsplit_pkg::SLOTS; i++) begin
      j = 3'(i) - la;
      if (3'(i) < la) begin
        push_grp.bytes[i] = (pa && i == 0) ? pbyte_r : nalsplit_pkg::BYTE_ZERO;
        push_grp.last[i]  = mlast && i == 0;
      end else begin
        push_grp.bytes[i] = (p_m && j == 3'd0) ? pb_m : nalsplit_pkg::BYTE_ZERO;
        push_grp.last[i]  = in_end && (3'(i) == total - 3'd1);
      end
    end
    push = in_fire && acc_r && pass_eff && total != 3'd0;

    type_nxt   = acc_r ? type_eff : type_r;
    pass_nxt   = acc_r ? pass_eff : pass_r;
    inside_nxt = inside_m;
    zr_nxt     = zr_m;
    p_nxt      = p_m;
    pbyte_nxt  = pb_m;
    head_nxt   = acc_r ? (head_eff && total == 3'd0) : head_r;
    if (in_end) begin
      acc_nxt    = 1'b0;
      pos_nxt    = 3'd0;
      inside_nxt = 1'b0;
      type_nxt   = 6'd0;
      pass_nxt   = 1'b0;
      zr_nxt     = 2'd0;
      p_nxt      = 1'b0;
      head_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= nalsplit_pkg::MASK_RESET;
      acc_r    <= 1'b0;
      pos_r    <= 3'd0;
      inside_r <= 1'b0;
      type_r   <= 6'd0;
      pass_r   <= 1'b0;
      zr_r     <= 2'd0;
      p_r      <= 1'b0;
      pbyte_r  <= 8'd0;
      head_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mask_r <= cfg_wr_data;
      end
      if (in_fire) begin
        acc_r    <= acc_nxt;
        pos_r    <= pos_nxt;
        inside_r <= inside_nxt;
        type_r   <= type_nxt;
        pass_r   <= pass_nxt;
        zr_r     <= zr_nxt;
        p_r      <= p_nxt;
        pbyte_r  <= pbyte_nxt;
        head_r   <= head_nxt;
      end
    end
  end

endmodule

// File: rtl/nalsplit_fifo.sv
// Short queue of result groups between front and back end.
module nalsplit_fifo #(
  parameter int unsigned DEPTH = nalsplit_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  nalsplit_pkg::grp_t  push_grp,
  input  logic                pop,
  output nalsplit_pkg::grp_t  pop_grp,
  output logic                empty,
  output logic                full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  nalsplit_pkg::grp_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign empty   = cnt_r == '0;
  assign full    = cnt_r == CW'(DEPTH);
  assign pop_grp = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// File: rtl/nalsplit_back.sv
// Back end: unpacks result groups into single-byte output transfers.
module nalsplit_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  nalsplit_pkg::grp_t  q_grp,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_payload_byte,
  output logic [5:0]          out_unit_type,
  output logic                out_unit_first,
  output logic                out_unit_last,
  output logic                out_run_last
);

  nalsplit_pkg::grp_t cur_r;
  logic               valid_r;
  logic [1:0]         idx_r;
  logic               last_slot;
  logic               advance;

  assign last_slot = idx_r == cur_r.cnt_m1;
  assign advance   = valid_r && out_ready && last_slot;
  assign q_pop     = !q_empty && (!valid_r || advance);

  assign out_valid        = valid_r;
  assign out_payload_byte = cur_r.bytes[idx_r];
  assign out_unit_type    = cur_r.utype;
  assign out_unit_first   = cur_r.first && idx_r == 2'd0;
  assign out_unit_last    = cur_r.last[idx_r];
  assign out_run_last     = last_slot;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (advance) begin
      valid_r <= 1'b0;
    end else if (valid_r && out_ready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule

// File: rtl/annexb_nal_splitter_epb_strip.sv
// Top level of the Annex-B NAL splitter with emulation-prevention byte removal.
//
//   channel | direction | payload                                    | handshake
//   in_     | input     | stream_byte, sample_end                    | valid/ready
//   out_    | output    | payload_byte, unit_type, unit_first,       | valid/ready
//           |           | unit_last, run_last                        |
//   cfg_    | input     | wr_data (type pass mask)                   | wr_en only
//
// One input byte per cycle while the group queue has space; the front end
// settles each byte combinationally. Each input byte yields 0..4 results,
// sent one per cycle by the back end while out_ready is high, so sustained
// output is one byte/cycle. The first result is registered in the queue and
// then in the back end. Synchronous active-low reset; no clearing pass. Output
// stalls back up through the queue into in_ready only once the queue is full.
module annexb_nal_splitter_epb_strip #(
  parameter int unsigned QUEUE_DEPTH = nalsplit_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  input  logic        in_sample_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_payload_byte,
  output logic [5:0]  out_unit_type,
  output logic        out_unit_first,
  output logic        out_unit_last,
  output logic        out_run_last
);

  nalsplit_pkg::grp_t push_grp;
  nalsplit_pkg::grp_t pop_grp;
  logic               push;
  logic               pop;
  logic               q_empty;
  logic               q_full;
  logic               in_fire;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  nalsplit_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_fire     (in_fire),
    .in_byte     (in_stream_byte),
    .in_end      (in_sample_end),
    .push        (push),
    .push_grp    (push_grp)
  );

  nalsplit_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .pop_grp  (pop_grp),
    .empty    (q_empty),
    .full     (q_full)
  );

  nalsplit_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_grp            (pop_grp),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_unit_type    (out_unit_type),
    .out_unit_first   (out_unit_first),
    .out_unit_last    (out_unit_last),
    .out_run_last     (out_run_last)
  );

endmodule

// File: verif/annexb_nal_splitter_epb_strip_tb.sv
// Self-checking testbench for the Annex-B NAL splitter with emulation-prevention removal.
module annexb_nal_splitter_epb_strip_tb;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned HOLD_OFF   = 240;
  localparam int unsigned SETTLE     = 8;
  localparam logic [5:0]  NAL_SPS    = 6'd33;

  typedef struct packed {
    logic [7:0] pb;
    logic [5:0] ty;
    logic       fst;
    logic       lst;
    logic       rl;
  } nal_res_t;

  typedef struct {
    logic [7:0] b;
    logic       e;
    int         typed;  // -1: from predictor, 0: no result, 1: the one result in r
    nal_res_t   r;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [63:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_stream_byte = '0;
  logic        in_sample_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_payload_byte;
  logic [5:0]  out_unit_type;
  logic        out_unit_first;
  logic        out_unit_last;
  logic        out_run_last;

  // predictor state
  logic [63:0] pass_mask;
  logic [7:0]  held [nalsplit_pkg::SLOTS];
  int          held_n;
  int          zrun;
  logic        in_unit;
  logic        cur_pass;
  logic        open_done;
  logic        head_due;
  logic [5:0]  cur_type;
  logic [2:0]  open_pos;
  nal_res_t    step_res[$];
  nal_res_t    nal_expect[$];

  stim_row_t   dir_tab[$];
  int          items_sent = 0;
  int          err_cnt = 0;
  int unsigned idle_run = 0;
  logic        tx_calm = 1'b0;
  logic        rx_calm = 1'b0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned rx_left = 0;

  annexb_nal_splitter_epb_strip dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_stream_byte   (in_stream_byte),
    .in_sample_end    (in_sample_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_unit_type    (out_unit_type),
    .out_unit_first   (out_unit_first),
    .out_unit_last    (out_unit_last),
    .out_run_last     (out_run_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic give_byte(input logic [7:0] b, input logic lst);
    if (cur_pass) step_res.push_back('{b, cur_type, head_due, lst, 1'b0});
    head_due = 1'b0;
  endtask

  task automatic flush_held(input int k, input logic mark);
    int i;
    if (k > held_n) k = held_n;
    for (i = 0; i < k; i++) give_byte(held[i], mark && (i + 1 == k));
    for (i = k; i < held_n; i++) held[i - k] = held[i];
    held_n -= k;
  endtask

  task automatic hold_byte(input logic [7:0] b);
    if (held_n < nalsplit_pkg::SLOTS) begin
      held[held_n] = b;
      held_n++;
    end
  endtask

  task automatic clear_sample();
    held      = '{default: 8'h00};
    held_n    = 0;
    zrun      = 0;
    in_unit   = 1'b0;
    cur_type  = '0;
    cur_pass  = 1'b0;
    open_pos  = '0;
    open_done = 1'b0;
    head_due  = 1'b0;
  endtask

  // Results caused by one stream byte, into step_res
  task automatic nal_predict(input logic [7:0] b, input logic e);
    logic have_p;
    int   i;
    step_res.delete();
    if (open_done) begin
      have_p = held_n > zrun;
      if (!in_unit) begin
        cur_type = b[6:1];
        cur_pass = pass_mask[b[6:1]];
        in_unit  = 1'b1;
        head_due = 1'b1;
      end
      if (b == nalsplit_pkg::BYTE_ZERO) begin
        if (zrun < 3) begin
          hold_byte(nalsplit_pkg::BYTE_ZERO);
          zrun++;
        end else begin
          if (have_p) flush_held(1, 1'b0);
          if (!(e && have_p)) hold_byte(nalsplit_pkg::BYTE_ZERO);
          zrun = 3;
        end
      end else if (b == nalsplit_pkg::BYTE_SC && zrun >= 2) begin
        if (have_p) give_byte(held[0], 1'b1);
        held_n  = 0;
        zrun    = 0;
        in_unit = 1'b0;
      end else if (b == nalsplit_pkg::BYTE_EPB && zrun >= 2) begin
        flush_held(held_n - 1, 1'b0);
        zrun = 0;
      end else begin
        // at most four results: lose one held zero
        if (e && held_n == nalsplit_pkg::SLOTS) begin
          for (i = 2; i < nalsplit_pkg::SLOTS; i++) held[i - 1] = held[i];
          held_n--;
        end
        flush_held(held_n, 1'b0);
        hold_byte(b);
        zrun = 0;
      end
    end else if (open_pos < nalsplit_pkg::POS_REJECT) begin
      if (b == nalsplit_pkg::BYTE_SC && open_pos >= 3'd2) begin
        open_done = 1'b1;
        in_unit   = 1'b0;
        zrun      = 0;
        held_n    = 0;
      end else if (b == nalsplit_pkg::BYTE_ZERO && open_pos < 3'd3) begin
        open_pos++;
      end else begin
        open_pos = nalsplit_pkg::POS_REJECT;
      end
    end
    if (e) begin
      flush_held(held_n, 1'b1);
      clear_sample();
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].rl = 1'b1;
  endtask

  function automatic void add_row(input logic [7:0] b, input logic e, input int typed,
                                  input nal_res_t r);
    dir_tab.push_back('{b, e, typed, r});
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic e, input int typed,
                           input nal_res_t r);
    int gap;
    int pick;
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    in_sample_end  <= e;
    do @(posedge clk); while (!in_ready);
    nal_predict(b, e);
    if (typed < 0) begin
      foreach (step_res[i]) nal_expect.push_back(step_res[i]);
    end else if (typed == 1) begin
      nal_expect.push_back(r);
    end
    items_sent++;
    gap = 0;
    if (!tx_calm) begin
      pick = $urandom_range(0, 99);
      if (pick >= 92) gap = $urandom_range(8, 30);
      else if (pick >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for every expected result, then for the pipe to empty
  task automatic settle();
    in_valid <= 1'b0;
    while (nal_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mask(input logic [63:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    pass_mask = v;
  endtask

  task automatic send_samples(input int quota);
    logic [7:0] smp[$];
    logic [5:0] ty;
    int         stop;
    int         kind;
    int         units;
    int         len;
    int         j;
    stop = items_sent + quota;
    while (items_sent < stop) begin
      smp.delete();
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        len = $urandom_range(1, 6);
        repeat (len) smp.push_back(kind < 4 ? 8'($urandom) : 8'($urandom_range(0, 3)));
      end else begin
        if ($urandom_range(0, 1) == 1) smp.push_back(nalsplit_pkg::BYTE_ZERO);
        smp.push_back(nalsplit_pkg::BYTE_ZERO);
        smp.push_back(nalsplit_pkg::BYTE_ZERO);
        smp.push_back(kind < 14 ? 8'($urandom_range(2, 255)) : nalsplit_pkg::BYTE_SC);
        units = $urandom_range(1, 4);
        for (j = 0; j < units; j++) begin
          if (j > 0) begin
            if ($urandom_range(0, 3) == 0) smp.push_back(nalsplit_pkg::BYTE_ZERO);
            smp.push_back(nalsplit_pkg::BYTE_ZERO);
            smp.push_back(nalsplit_pkg::BYTE_ZERO);
            smp.push_back(nalsplit_pkg::BYTE_SC);
          end
          if ($urandom_range(0, 9) == 0) continue;
          ty = ($urandom_range(0, 1) == 1) ? 6'($urandom_range(32, 40)) : 6'($urandom);
          smp.push_back({1'($urandom), ty, 1'($urandom)});
          smp.push_back(8'($urandom));
          len = $urandom_range(0, 5);
          repeat (len) begin
            case ($urandom_range(0, 5))
              1: begin
                smp.push_back(nalsplit_pkg::BYTE_ZERO);
                smp.push_back(nalsplit_pkg::BYTE_ZERO);
                smp.push_back(nalsplit_pkg::BYTE_EPB);
              end
              2: repeat ($urandom_range(1, 4)) smp.push_back(nalsplit_pkg::BYTE_ZERO);
              3: smp.push_back(8'($urandom_range(1, 3)));
              default: smp.push_back(8'($urandom));
            endcase
          end
        end
      end
      for (j = 0; j < smp.size(); j++) send_byte(smp[j], j == smp.size() - 1, -1, '0);
    end
  endtask

  task automatic note_bad(input string what, input nal_res_t want, input nal_res_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%s: byte type first last run_last: expected %h %0d %b %b %b, got %h %0d %b %b %b",
               what, want.pb, want.ty, want.fst, want.lst, want.rl,
               got.pb, got.ty, got.fst, got.lst, got.rl);
  endtask

  always @(posedge clk) begin
    nal_res_t got;
    nal_res_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_payload_byte, out_unit_type, out_unit_first, out_unit_last, out_run_last};
      if (nal_expect.size() == 0) begin
        note_bad("unexpected transfer", '0, got);
      end else begin
        want = nal_expect.pop_front();
        if (want != got) note_bad("wrong transfer", want, got);
      end
    end
  end

  always @(posedge clk) begin
    int unsigned pick;
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      rx_left   <= HOLD_OFF;
      out_ready <= 1'b0;
    end else if (rx_left != 0) begin
      rx_left   <= rx_left - 1;
      out_ready <= 1'b0;
    end else if (rx_calm) begin
      out_ready <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      out_ready <= (pick < 65);
      if (pick >= 95) rx_left <= $urandom_range(8, 30);
      else if (pick >= 65) rx_left <= $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      idle_run <= 0;
    end else if (idle_run == IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    pass_mask = nalsplit_pkg::MASK_RESET;
    clear_sample();

    // 4-byte opening, VPS unit with an escape, ended by the sample end
    add_row(nalsplit_pkg::BYTE_ZERO, 1'b0, 0, '0);
    add_row(nalsplit_pkg::BYTE_ZERO, 1'b0, 0, '0);
    add_row(nalsplit_pkg::BYTE_ZERO, 1'b0, 0, '0);
    add_row(nalsplit_pkg::BYTE_SC,   1'b0, 0, '0);
    add_row(8'h40,                   1'b0, 0, '0);
    add_row(nalsplit_pkg::BYTE_ZERO, 1'b0, 0, '0);
    add_row(nalsplit_pkg::BYTE_ZERO, 1'b0, 0, '0);
    add_row(nalsplit_pkg::BYTE_EPB,  1'b0, -1, '0);
    add_row(8'hFF,                   1'b1, -1, '0);
    // rejected opening
    add_row(nalsplit_pkg::BYTE_ZERO, 1'b0, 0, '0);
    add_row(8'h02,                   1'b0, 0, '0);
    add_row(8'hFF,                   1'b1, 0, '0);
    // 3-byte opening, 4-byte code trims a zero, empty unit, overlong zero run at the end
    add_row(nalsplit_pkg::BYTE_ZERO, 1'b0, 0, '0);
    add_row(nalsplit_pkg::BYTE_ZERO, 1'b0, 0, '0);
    add_row(nalsplit_pkg::BYTE_SC,   1'b0, 0, '0);
    add_row(8'h42,                   1'b0, 0, '0);
    add_row(nalsplit_pkg::BYTE_ZERO, 1'b0, 0, '0);
    add_row(nalsplit_pkg::BYTE_ZERO, 1'b0, 0, '0);
    add_row(nalsplit_pkg::BYTE_ZERO, 1'b0, 0, '0);
    add_row(nalsplit_pkg::BYTE_SC,   1'b0, 1, '{8'h42, NAL_SPS, 1'b1, 1'b1, 1'b1});
    add_row(nalsplit_pkg::BYTE_ZERO, 1'b0, 0, '0);
    add_row(nalsplit_pkg::BYTE_ZERO, 1'b0, 0, '0);
    add_row(nalsplit_pkg::BYTE_SC,   1'b0, 0, '0);
    add_row(8'h4E,                   1'b0, 0, '0);
    add_row(nalsplit_pkg::BYTE_ZERO, 1'b0, 0, '0);
    add_row(nalsplit_pkg::BYTE_ZERO, 1'b0, 0, '0);
    add_row(nalsplit_pkg::BYTE_ZERO, 1'b0, 0, '0);
    add_row(8'h7F,                   1'b1, -1, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_byte(dir_tab[i].b, dir_tab[i].e, dir_tab[i].typed, dir_tab[i].r);

    set_mask('1);
    send_samples(60);
    set_mask('0);
    send_samples(30);

    // long receiver hold-off while the sender keeps offering
    set_mask({$urandom, $urandom});
    tx_calm = 1'b1;
    hold_reqs++;
    send_samples(50);
    tx_calm = 1'b0;

    set_mask({$urandom, $urandom});
    tx_calm = 1'b1;
    rx_calm <= 1'b1;
    send_samples(40);
    tx_calm = 1'b0;
    rx_calm <= 1'b0;

    set_mask(nalsplit_pkg::MASK_RESET | 64'(1) << $urandom_range(0, 63));
    send_samples(40);
    set_mask({$urandom, $urandom});
    send_samples(50);

    settle();
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
